// ===== design/sfp_pkg.sv =====
`timescale 1ns / 1ps

package sfp_pkg;

  // Frame limits and field widths
  localparam int DATA_MAX  = 64;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int POS_W     = 6;
  localparam int STORE_D   = 64;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h55;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 2'd1;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [LEN_W-1:0]  length;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_cmd;
    logic load_len;
    logic store_byte;
    logic clr_pos;
    logic read_en;
    logic step_pos;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_head;
    logic len_ok;
    logic len_zero;
    logic data_done;
    logic sum_ok;
    logic tail_ok;
    logic out_last;
  } sts_t;

endpackage

// ===== design/sfp_if.sv =====
`timescale 1ns / 1ps

// Received byte channel
interface sfp_byte_if;
  import sfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel
interface sfp_result_if;
  import sfp_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Register write channel
interface sfp_cfg_if;
  import sfp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/serial_frame_parser.sv =====
`timescale 1ns / 1ps

// Serial frame parser.
// rx_if takes one received byte per transfer. Frames are head, command,
// length (0..64), payload, XOR checksum over command/length/payload, tail.
// Bad length, checksum or tail drops the frame; a head byte restarts it.
// res_if delivers one result per payload byte (one result for an empty
// frame), the final one flagged by last. cfg_if writes head_byte (index 0)
// and tail_byte (index 1); it is always ready, other indexes are ignored.
// Throughput: while a frame arrives, one byte per cycle. On the tail
// transfer rx_if drops ready and the payload store drains: each result
// passes a RAM read state (S_RD), then a presentation state (S_OUT)
// that waits while the receiver holds ready low; the store's single
// read port serves one result at a time. First result is valid in S_OUT;
// rx_if is ready again in the cycle after the last result transfers.
// A stalled result holds its payload until taken.
// Reset (rst_ni low, asynchronous) returns to head hunting and restores
// head 0xAA and tail 0x55; the payload store is not cleared.
module serial_frame_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  sfp_byte_if.sink       rx_if,
  sfp_result_if.source   res_if,
  sfp_cfg_if.sink        cfg_if
);
  import sfp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;

  assign cfg_if.ready = 1'b1;
  assign res_if.data  = res;

  sfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_if.valid),
    .rx_ready_o  (rx_if.ready),
    .res_valid_o (res_if.valid),
    .res_ready_i (res_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sfp_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (rx_if.data),
    .cfg_we_i   (cfg_if.valid),
    .cfg_idx_i  (cfg_if.index),
    .cfg_data_i (cfg_if.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res)
  );

endmodule

// ===== design/sfp_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read
module sfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sfp_datapath.sv =====
`timescale 1ns / 1ps

module sfp_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [sfp_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic                       cfg_we_i,
  input  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sfp_pkg::BYTE_W-1:0] cfg_data_i,
  input  sfp_pkg::cmd_t              cmd_i,
  output sfp_pkg::sts_t              sts_o,
  output sfp_pkg::res_t              res_o
);
  import sfp_pkg::*;

  localparam logic [BYTE_W-1:0] DATA_MAX_B = BYTE_W'(DATA_MAX);

  logic [BYTE_W-1:0] head_q, tail_q;
  logic [BYTE_W-1:0] cmd_q, xor_q, xor_d;
  logic [LEN_W-1:0]  len_q, cnt_q, cnt_inc;
  logic [POS_W-1:0]  pos_q;
  logic [BYTE_W-1:0] rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= HEAD_RESET;
      tail_q <= TAIL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEAD: head_q <= cfg_data_i;
        CFG_TAIL: tail_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame fields, byte count and running checksum
  assign cnt_inc = cnt_q + LEN_W'(1);

  always_comb begin
    xor_d = xor_q;
    if (cmd_i.load_cmd) begin
      xor_d = rx_byte_i;
    end else if (cmd_i.load_len || cmd_i.store_byte) begin
      xor_d = xor_q ^ rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
      len_q <= '0;
      cnt_q <= '0;
      xor_q <= '0;
      pos_q <= '0;
    end else begin
      xor_q <= xor_d;
      if (cmd_i.load_cmd) begin
        cmd_q <= rx_byte_i;
      end
      if (cmd_i.load_len) begin
        len_q <= rx_byte_i[LEN_W-1:0];
        cnt_q <= '0;
      end else if (cmd_i.store_byte) begin
        cnt_q <= cnt_inc;
      end
      if (cmd_i.clr_pos) begin
        pos_q <= '0;
      end else if (cmd_i.step_pos) begin
        pos_q <= pos_q + POS_W'(1);
      end
    end
  end

  // Payload store
  sfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_D)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_byte),
    .waddr_i (cnt_q[POS_W-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.read_en),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  // Status for the controller
  assign sts_o.is_head   = (rx_byte_i == head_q);
  assign sts_o.len_ok    = (rx_byte_i <= DATA_MAX_B);
  assign sts_o.len_zero  = (rx_byte_i == '0);
  assign sts_o.data_done = (cnt_inc >= len_q);
  assign sts_o.sum_ok    = (rx_byte_i == xor_q);
  assign sts_o.tail_ok   = (rx_byte_i == tail_q);
  assign sts_o.out_last  = (len_q == '0) || (({1'b0, pos_q} + LEN_W'(1)) == len_q);

  // Result fields; an empty frame shows a zero payload byte
  assign res_o.command      = cmd_q;
  assign res_o.length       = len_q;
  assign res_o.position     = pos_q;
  assign res_o.payload_byte = (len_q == '0) ? '0 : rdata;
  assign res_o.last         = sts_o.out_last;

endmodule

// ===== design/sfp_ctrl.sv =====
`timescale 1ns / 1ps

module sfp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rx_valid_i,
  output logic          rx_ready_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  input  sfp_pkg::sts_t sts_i,
  output sfp_pkg::cmd_t cmd_o
);
  import sfp_pkg::*;

  localparam logic [2:0] S_HEAD = 3'd0;
  localparam logic [2:0] S_CMD  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_DATA = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_TAIL = 3'd5;
  localparam logic [2:0] S_RD   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       rx_fire;
  logic [2:0] drop_state;

  assign rx_ready_o  = (state_q != S_RD) && (state_q != S_OUT);
  assign res_valid_o = (state_q == S_OUT);
  assign rx_fire     = rx_valid_i && rx_ready_o;
  // A dropped frame restarts at once on a head byte
  assign drop_state  = sts_i.is_head ? S_CMD : S_HEAD;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_HEAD: begin
        if (rx_fire && sts_i.is_head) state_d = S_CMD;
      end
      S_CMD: begin
        if (rx_fire) begin
          cmd_o.load_cmd = 1'b1;
          state_d        = S_LEN;
        end
      end
      S_LEN: begin
        if (rx_fire) begin
          if (!sts_i.len_ok) begin
            state_d = drop_state;
          end else begin
            cmd_o.load_len = 1'b1;
            state_d        = sts_i.len_zero ? S_SUM : S_DATA;
          end
        end
      end
      S_DATA: begin
        if (rx_fire) begin
          cmd_o.store_byte = 1'b1;
          if (sts_i.data_done) state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (rx_fire) state_d = sts_i.sum_ok ? S_TAIL : drop_state;
      end
      S_TAIL: begin
        if (rx_fire) begin
          if (sts_i.tail_ok) begin
            cmd_o.clr_pos = 1'b1;
            state_d       = S_RD;
          end else begin
            state_d = drop_state;
          end
        end
      end
      S_RD: begin
        cmd_o.read_en = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (res_ready_i) begin
          if (sts_i.out_last) begin
            state_d = S_HEAD;
          end else begin
            cmd_o.step_pos = 1'b1;
            state_d        = S_RD;
          end
        end
      end
      default: state_d = S_HEAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HEAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/sfp_checker.sv =====
`timescale 1ns / 1ps

module sfp_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rx_ready_i,
  input  logic          res_valid_i,
  input  logic          res_ready_i,
  input  sfp_pkg::res_t res_i
);
  import sfp_pkg::*;

  // No byte is taken while a result is on offer
  a_no_rx_during_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !rx_ready_i)
    else $error("byte channel ready while a result is pending");

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_i))
    else $error("stalled result changed");

  // After the final transfer of a frame, the byte channel reopens
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && res_i.last |=> rx_ready_i && !res_valid_i)
    else $error("byte channel did not reopen after frame end");

  // An empty frame's result is flagged last at position 0; positions stay in range
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> ((res_i.length == '0) && res_i.last && (res_i.position == '0))
                    || (({1'b0, res_i.position}) < res_i.length))
    else $error("result position out of range");

endmodule

bind serial_frame_parser sfp_checker u_sfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rx_ready_i  (rx_if.ready),
  .res_valid_i (res_if.valid),
  .res_ready_i (res_if.ready),
  .res_i       (res_if.data)
);
